// File: design/vcei_pkg.sv
// shared constants and state encoding for the velocity clamp euler integrator
package vcei_pkg;

  localparam int unsigned ENTITY_COUNT_DEF = 1024;
  localparam int unsigned ENTITY_W         = 10;
  localparam int unsigned FRAME_STEP_W     = 17;
  localparam logic [16:0] FRAME_STEP_RESET = 17'd1092;

  // pi and two pi in q16.16
  localparam logic signed [34:0] PI_Q     = 35'sd205887;
  localparam logic signed [34:0] TWO_PI_Q = 35'sd411774;

  localparam logic CMD_PLACE = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

  typedef enum logic [10:0] {
    ST_IDLE = 11'b000_0000_0001,
    ST_SQ   = 11'b000_0000_0010,
    ST_SUM  = 11'b000_0000_0100,
    ST_CMP  = 11'b000_0000_1000,
    ST_ROOT = 11'b000_0001_0000,
    ST_SMUL = 11'b000_0010_0000,
    ST_DIV  = 11'b000_0100_0000,
    ST_FMUL = 11'b000_1000_0000,
    ST_ADD  = 11'b001_0000_0000,
    ST_WB   = 11'b010_0000_0000,
    ST_SPARE = 11'b100_0000_0000
  } vcei_state_t;

endpackage

// File: design/velocity_clamp_euler_integrator.sv
// pose table with euler integration and a linear speed clamp
//
// usage:
//   input channel (in_valid / in_stall) carries one command per transfer.
//   a place command (in_command = 0) writes position and rotation of one
//   entity into the pose memory in the cycle of its transfer; no result.
//   a step command (in_command = 1) clamps the linear velocity to
//   in_speed_limit, integrates position (saturating) and rotation (one
//   wrap of two pi per axis) over frame_step, writes the pose back and
//   returns one result transfer on out_valid / out_stall.
//   an entity index at or above ENTITY_COUNT is dropped without a result.
//   cfg_valid / cfg_ready writes frame_step; cfg_ready is always high.
// sequence:
//   place: does not raise in_stall. step: square, sum, compare,
//   with clamping the bit-serial square root (32 steps) and the three
//   parallel restoring dividers (31 steps), frame multiply, add, write-back.
//   one item is in work at a time; in_stall is high while it runs.
// reset: synchronous, clears control state and sets frame_step to 1092;
//   the pose memory is not cleared, entries are undefined until placed.
// stall: a finished result waits in the output register while
//   out_stall is high; the next command is taken meanwhile, and a step
//   holds in its write-back state until the output register frees up.
module velocity_clamp_euler_integrator
  import vcei_pkg::*;
#(
  parameter int unsigned ENTITY_COUNT = ENTITY_COUNT_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // configuration
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [16:0]             cfg_frame_step,
  // command channel
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    in_command,
  input  logic [9:0]              in_entity,
  input  logic signed [31:0]      in_first_x,
  input  logic signed [31:0]      in_first_y,
  input  logic signed [31:0]      in_first_z,
  input  logic signed [31:0]      in_second_x,
  input  logic signed [31:0]      in_second_y,
  input  logic signed [31:0]      in_second_z,
  input  logic [30:0]             in_speed_limit,
  // result channel
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [9:0]              out_entity_out,
  output logic signed [31:0]      out_vel_x,
  output logic signed [31:0]      out_vel_y,
  output logic signed [31:0]      out_vel_z,
  output logic signed [31:0]      out_pos_x,
  output logic signed [31:0]      out_pos_y,
  output logic signed [31:0]      out_pos_z,
  output logic signed [31:0]      out_rot_x,
  output logic signed [31:0]      out_rot_y,
  output logic signed [31:0]      out_rot_z
);

  // only entities reachable through the 10-bit index need storage
  localparam int unsigned DEPTH = (ENTITY_COUNT < 1024) ? ENTITY_COUNT : 1024;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
    logic signed [31:0] res;
    if (v > 35'sd2147483647)       res = 32'sh7fff_ffff;
    else if (v < -35'sd2147483648) res = 32'sh8000_0000;
    else                           res = v[31:0];
    return res;
  endfunction

  vcei_state_t state_r, state_nxt;

  logic [16:0]  fs_r;
  logic         out_valid_r;
  logic         take;
  logic         step_go;
  logic         in_range;
  logic         out_free;

  // per-item registers
  logic [9:0]   entity_r;
  logic [30:0]  limit_r;
  logic         clamped_r;
  logic [31:0]  mag_r  [3];
  logic         neg_r  [3];
  logic [31:0]  amag_r [3];
  logic         aneg_r [3];

  // speed test
  logic [62:0]  sq_r [3];
  logic [61:0]  lim2_r;
  logic [63:0]  sum_r;

  // square root
  logic [63:0]  rad_r;
  logic [33:0]  rem_r;
  logic [31:0]  root_r;
  logic [4:0]   cnt_r;

  // dividers
  logic [31:0]  div_r;
  logic [31:0]  drem_r [3];
  logic [30:0]  dlo_r  [3];

  // frame products and results
  logic [32:0]  fq_r [3];
  logic [32:0]  aq_r [3];
  logic signed [31:0] vel_r [3];
  logic signed [31:0] pos_r [3];
  logic signed [31:0] rot_r [3];

  // pose memory: position in the low half, rotation in the high half
  logic [191:0] mem [DEPTH];
  logic [191:0] mem_q;

  logic [31:0]  first_v  [3];
  logic [31:0]  second_v [3];
  logic [31:0]  vmag     [3];

  assign first_v[0]  = in_first_x;
  assign first_v[1]  = in_first_y;
  assign first_v[2]  = in_first_z;
  assign second_v[0] = in_second_x;
  assign second_v[1] = in_second_y;
  assign second_v[2] = in_second_z;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != ST_IDLE);
  assign take      = in_valid && !in_stall;
  assign in_range  = 32'(in_entity) < ENTITY_COUNT;
  assign step_go   = take && in_range && (in_command == CMD_STEP);
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;

  // velocity magnitude after the clamp
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      vmag[i] = clamped_r ? {1'b0, dlo_r[i]} : mag_r[i];
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (step_go) state_nxt = ST_SQ;
      ST_SQ:   state_nxt = ST_SUM;
      ST_SUM:  state_nxt = ST_CMP;
      ST_CMP:  state_nxt = (sum_r > {2'd0, lim2_r}) ? ST_ROOT : ST_FMUL;
      ST_ROOT: if (cnt_r == 5'd31) state_nxt = ST_SMUL;
      ST_SMUL: state_nxt = ST_DIV;
      ST_DIV:  if (cnt_r == 5'd30) state_nxt = ST_FMUL;
      ST_FMUL: state_nxt = ST_ADD;
      ST_ADD:  state_nxt = ST_WB;
      ST_WB:   if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fs_r        <= FRAME_STEP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) fs_r <= cfg_frame_step;
      if (state_r == ST_WB && out_free) out_valid_r <= 1'b1;
      else if (!out_stall)              out_valid_r <= 1'b0;
    end
  end

  // memory port: write on place transfer or step write-back, read every cycle
  always_ff @(posedge clk) begin
    if (take && in_range && (in_command == CMD_PLACE)) begin
      mem[in_entity[AW-1:0]] <= {in_second_z, in_second_y, in_second_x,
                                 in_first_z, in_first_y, in_first_x};
    end else if (state_r == ST_WB && out_free) begin
      mem[entity_r[AW-1:0]] <= {rot_r[2], rot_r[1], rot_r[0],
                                pos_r[2], pos_r[1], pos_r[0]};
    end
    mem_q <= mem[entity_r[AW-1:0]];
  end

  // datapath
  always_ff @(posedge clk) begin
    logic [63:0] sq_c;
    logic [63:0] lim_c;
    logic [63:0] pr_c;
    logic [48:0] fm_c;
    logic [48:0] am_c;
    logic [35:0] rt_c;
    logic [35:0] tr_c;
    logic [32:0] dt_c;
    logic signed [34:0] p_c;
    logic signed [34:0] r_c;
    logic signed [34:0] d_c;
    logic signed [34:0] a_c;

    lim_c = {33'd0, limit_r} * {33'd0, limit_r};
    rt_c  = {rem_r, rad_r[63:62]};
    tr_c  = {2'd0, root_r, 2'b01};

    if (step_go) begin
      entity_r <= in_entity;
      limit_r  <= in_speed_limit;
      for (int i = 0; i < 3; i++) begin
        neg_r[i]  <= first_v[i][31];
        mag_r[i]  <= first_v[i][31] ? 32'(-first_v[i]) : first_v[i];
        aneg_r[i] <= second_v[i][31];
        amag_r[i] <= second_v[i][31] ? 32'(-second_v[i]) : second_v[i];
      end
    end

    case (state_r)
      ST_SQ: begin
        for (int i = 0; i < 3; i++) begin
          sq_c     = {32'd0, mag_r[i]} * {32'd0, mag_r[i]};
          sq_r[i] <= sq_c[62:0];
        end
        lim2_r <= lim_c[61:0];
      end
      ST_SUM: begin
        sum_r <= {1'b0, sq_r[0]} + {1'b0, sq_r[1]} + {1'b0, sq_r[2]};
      end
      ST_CMP: begin
        clamped_r <= sum_r > {2'd0, lim2_r};
        rad_r     <= sum_r;
        rem_r     <= '0;
        root_r    <= '0;
        cnt_r     <= '0;
      end
      ST_ROOT: begin
        // one result bit per cycle
        rad_r <= {rad_r[61:0], 2'b00};
        cnt_r <= cnt_r + 5'd1;
        if (rt_c >= tr_c) begin
          rem_r  <= 34'(rt_c - tr_c);
          root_r <= {root_r[30:0], 1'b1};
        end else begin
          rem_r  <= rt_c[33:0];
          root_r <= {root_r[30:0], 1'b0};
        end
      end
      ST_SMUL: begin
        div_r <= (root_r == '0) ? 32'd1 : root_r;
        cnt_r <= '0;
        for (int i = 0; i < 3; i++) begin
          pr_c       = {32'd0, mag_r[i]} * {33'd0, limit_r};
          drem_r[i] <= {1'b0, pr_c[61:31]};
          dlo_r[i]  <= pr_c[30:0];
        end
      end
      ST_DIV: begin
        cnt_r <= cnt_r + 5'd1;
        for (int i = 0; i < 3; i++) begin
          dt_c = {drem_r[i], dlo_r[i][30]};
          if (dt_c >= {1'b0, div_r}) begin
            drem_r[i] <= 32'(dt_c - {1'b0, div_r});
            dlo_r[i]  <= {dlo_r[i][29:0], 1'b1};
          end else begin
            drem_r[i] <= dt_c[31:0];
            dlo_r[i]  <= {dlo_r[i][29:0], 1'b0};
          end
        end
      end
      ST_FMUL: begin
        for (int i = 0; i < 3; i++) begin
          fm_c     = {17'd0, vmag[i]} * {32'd0, fs_r};
          am_c     = {17'd0, amag_r[i]} * {32'd0, fs_r};
          fq_r[i] <= fm_c[48:16];
          aq_r[i] <= am_c[48:16];
          vel_r[i] <= neg_r[i] ? 32'(-vmag[i]) : vmag[i];
        end
      end
      ST_ADD: begin
        for (int i = 0; i < 3; i++) begin
          d_c = neg_r[i]  ? -$signed({2'b00, fq_r[i]}) : $signed({2'b00, fq_r[i]});
          a_c = aneg_r[i] ? -$signed({2'b00, aq_r[i]}) : $signed({2'b00, aq_r[i]});
          p_c = 35'($signed(mem_q[i*32 +: 32])) + d_c;
          r_c = 35'($signed(mem_q[96 + i*32 +: 32])) + a_c;
          // one wrap correction per axis
          if (r_c > PI_Q)       r_c = r_c - TWO_PI_Q;
          else if (r_c < -PI_Q) r_c = r_c + TWO_PI_Q;
          pos_r[i] <= sat32(p_c);
          rot_r[i] <= sat32(r_c);
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (state_r == ST_WB && out_free) begin
      out_entity_out <= entity_r;
      out_vel_x      <= vel_r[0];
      out_vel_y      <= vel_r[1];
      out_vel_z      <= vel_r[2];
      out_pos_x      <= pos_r[0];
      out_pos_y      <= pos_r[1];
      out_pos_z      <= pos_r[2];
      out_rot_x      <= rot_r[0];
      out_rot_y      <= rot_r[1];
      out_rot_z      <= rot_r[2];
    end
  end

endmodule

// File: design/vcei_checker.sv
// port-level checker for the velocity clamp euler integrator, with its bind
module vcei_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               in_command,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [31:0] out_pos_x
);

  // reset leaves the block idle with no result pending
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("block not idle after reset");

  // a place transfer completes in its own cycle
  a_place_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !in_command |=> !in_stall)
    else $error("place command held the input");

  // a new result only comes out of a running step
  a_result_from_step: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without a step in work");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_pos_x))
    else $error("stalled result changed");

endmodule

bind velocity_clamp_euler_integrator vcei_checker u_vcei_checker (.*);
